FILE: sv/bpfm_pkg.sv
package bpfm_pkg;

  // Fixed widths of the item fields and of the control fields
  localparam int FIELD_W = 56;
  localparam int PIV_W   = 5;
  localparam int TRI_W   = 6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLOSE,
    ST_CHECK
  } state_e;

  typedef struct packed {
    logic             load;
    logic             step;
    logic             check;
    logic [PIV_W-1:0] pivot;
  } cmd_t;

  // Lexicographic number of the root (a, b), a < b, among w wires
  function automatic int pair_idx(input int a, input int b, input int w);
    int base;
    base = a * w - ((a * (a + 1)) >> 1);
    return base + b - a - 1;
  endfunction

endpackage

FILE: sv/bpfm_ctrl.sv
module bpfm_ctrl #(
  parameter int NROOTS = 28
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  output bpfm_pkg::cmd_t cmd_o
);
  import bpfm_pkg::*;

  state_e           state_q, state_d;
  logic [PIV_W-1:0] piv_q, piv_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      piv_q   <= '0;
    end else begin
      state_q <= state_d;
      piv_q   <= piv_d;
    end
  end

  always_comb begin
    state_d = state_q;
    piv_d   = piv_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          piv_d      = '0;
          state_d    = ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        cmd_o.step  = 1'b1;
        cmd_o.pivot = piv_q;
        // advance the pivot until every root has served once
        if (piv_q == PIV_W'(NROOTS - 1)) begin
          state_d = ST_CHECK;
        end else begin
          piv_d = piv_q + PIV_W'(1);
        end
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

FILE: sv/bpfm_dp.sv
module bpfm_dp #(
  parameter int WIRES = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bpfm_pkg::cmd_t               cmd_i,
  input  logic [bpfm_pkg::FIELD_W-1:0] bits_i,
  output logic                         valid_o,
  output logic [bpfm_pkg::FIELD_W-1:0] mask_o
);
  import bpfm_pkg::*;

  localparam int NROOTS = WIRES * (WIRES - 1) / 2;
  localparam int PW     = (NROOTS > 1) ? $clog2(NROOTS) : 1;

  logic [NROOTS-1:0]  rel_q [NROOTS];
  logic [NROOTS-1:0]  rel_d [NROOTS];
  logic [NROOTS-1:0]  init_rel [NROOTS];
  logic [FIELD_W-1:0] bits_q;
  logic [FIELD_W-1:0] mask_q, mask_d;
  logic               valid_q;
  logic [PW-1:0]      piv;
  logic [NROOTS-1:0]  prow;

  // Direct precedence edges from the orientation of each triple
  always_comb begin
    logic [PW-1:0]    lo, mid, hi;
    logic [TRI_W-1:0] k;
    k = '0;
    for (int i = 0; i < NROOTS; i++) begin
      init_rel[i] = '0;
    end
    for (int a = 0; a < WIRES; a++) begin
      for (int b = a + 1; b < WIRES; b++) begin
        for (int c = b + 1; c < WIRES; c++) begin
          lo  = PW'(pair_idx(a, b, WIRES));
          mid = PW'(pair_idx(a, c, WIRES));
          hi  = PW'(pair_idx(b, c, WIRES));
          if (bits_i[k]) begin
            init_rel[hi][mid] = 1'b1;
            init_rel[mid][lo] = 1'b1;
          end else begin
            init_rel[lo][mid] = 1'b1;
            init_rel[mid][hi] = 1'b1;
          end
          k = k + TRI_W'(1);
        end
      end
    end
  end

  // One Warshall pivot: every row that reaches the pivot takes its row
  assign piv  = cmd_i.pivot[PW-1:0];
  assign prow = rel_q[piv];

  always_comb begin
    for (int i = 0; i < NROOTS; i++) begin
      rel_d[i] = rel_q[i][piv] ? (rel_q[i] | prow) : rel_q[i];
    end
  end

  // Interval test of every triple on the closed relation
  always_comb begin
    logic [PW-1:0]     lo, mid, hi, first, last;
    logic [TRI_W-1:0]  k;
    logic [NROOTS-1:0] col, span, want;
    k      = '0;
    mask_d = '0;
    for (int a = 0; a < WIRES; a++) begin
      for (int b = a + 1; b < WIRES; b++) begin
        for (int c = b + 1; c < WIRES; c++) begin
          lo    = PW'(pair_idx(a, b, WIRES));
          mid   = PW'(pair_idx(a, c, WIRES));
          hi    = PW'(pair_idx(b, c, WIRES));
          first = bits_q[k] ? hi : lo;
          last  = bits_q[k] ? lo : hi;
          for (int i = 0; i < NROOTS; i++) begin
            col[i] = rel_q[i][last];
          end
          span = (rel_q[first] & col) | (NROOTS'(1) << first) | (NROOTS'(1) << last);
          want = (NROOTS'(1) << lo) | (NROOTS'(1) << mid) | (NROOTS'(1) << hi);
          mask_d[k] = (span == want);
          k = k + TRI_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rel_q  <= init_rel;
      bits_q <= bits_i;
    end else if (cmd_i.step) begin
      rel_q <= rel_d;
    end
    if (cmd_i.check) begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.check;
    end
  end

  assign valid_o = valid_q;
  assign mask_o  = mask_q;

endmodule

FILE: sv/bruhat_packet_flip_mask.sv
// Flip-mask detector for B(WIRES,2). Raise start with the orientation bits
// while busy is low; the item is taken at that edge and busy rises. The
// block builds the root precedence relation, closes it with one Warshall
// pivot per cycle, one pivot for every root, tests every triple in the
// check state and then shows the mask on flippable_mask_o for one cycle
// with valid_o high. The receiver cannot hold the result off, so latch it
// on that strobe. busy is low again in the strobe cycle, so a new item may
// start there; no new item is taken while busy is high.
module bruhat_packet_flip_mask #(
  parameter int WIRES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [55:0] orientation_bits_i,
  output logic        valid_o,
  output logic [55:0] flippable_mask_o
);
  import bpfm_pkg::*;

  localparam int NROOTS = WIRES * (WIRES - 1) / 2;

  cmd_t cmd;

  bpfm_ctrl #(
    .NROOTS (NROOTS)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .cmd_o   (cmd)
  );

  bpfm_dp #(
    .WIRES (WIRES)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .bits_i  (orientation_bits_i),
    .valid_o (valid_o),
    .mask_o  (flippable_mask_o)
  );

endmodule
